// ===== sv/cdq_pkg.sv =====
// Package for the circular deque with search: sizes, operation and status
// codes, the command and result transaction types and the ring index helper.
// No dependencies.
package cdq_pkg;

  // Store geometry.
  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);

  // Fixed field widths of the transactions.
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned OCC_W   = 7;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Command transaction.
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // Result transaction.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [POS_W-1:0]  position;
    logic [OCC_W-1:0]  occupancy;
  } res_t;

  // Ring slot that lies a given offset behind the front entry.
  function automatic idx_t slot_of(input idx_t front, input cnt_t offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(front) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return IDX_W'(sum);
  endfunction

endpackage

// ===== sv/cdq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/circular_deque_with_search_core.sv =====
// Top level of the circular deque with search: front index, count, sequencer
// and result register around one ring store. Depends on cdq_pkg and cdq_ram.
//
// Usage:
//   A command transaction (cmd_i: mode and value) is taken at a rising edge
//   where start_i is high and busy_o is low. Every command yields exactly one
//   result transaction on res_o, shown for one cycle with valid_o high.
//   Pushes, pops, invalid modes and searches of an empty deque are done in
//   the accepting cycle; their result appears in the next cycle and busy_o
//   stays low, so a new command may follow at once.
//   A search holds busy_o high while it walks the ring store from the front,
//   one entry per cycle through the store's single read port with a
//   registered read. A match at position p is reported when that entry is
//   compared, and a miss when the last stored entry is compared; busy_o falls
//   with the result.
//   There is no back-pressure: the receiver must take each result in the
//   cycle it is shown.
//   Reset (rst_ni low, asynchronous) empties the deque, zeroes the front
//   index and drops any search in flight. Store contents are not cleared;
//   only entries holding stored words are ever read.
module circular_deque_with_search_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cdq_pkg::cmd_t cmd_i,
  output logic          valid_o,
  output cdq_pkg::res_t res_o
);

  import cdq_pkg::*;

  // Sequencer states.
  localparam logic STATE_IDLE   = 1'b0;
  localparam logic STATE_SEARCH = 1'b1;

  logic  state_q, state_d;
  idx_t  front_q, front_d;
  cnt_t  cnt_q, cnt_d;
  cnt_t  iss_q, iss_d;
  cnt_t  cmp_off_q, cmp_off_d;
  logic  cmp_vld_q, cmp_vld_d;
  word_t key_q, key_d;
  logic  valid_q, valid_d;
  res_t  res_q, res_d;

  logic  accept;
  word_t word_in;
  logic  ram_we;
  idx_t  ram_waddr;
  logic  ram_re;
  idx_t  ram_raddr;
  word_t ram_rdata;

  assign accept  = start_i && (state_q == STATE_IDLE);
  assign word_in = WORD_BITS'(cmd_i.value);

  // Ring store.
  cdq_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(CAPACITY)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(word_in),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Command decode, search walk and result formation.
  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    cmp_off_d = cmp_off_q;
    cmp_vld_d = 1'b0;
    key_d     = key_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = front_q;
    ram_re    = 1'b0;
    ram_raddr = slot_of(front_q, iss_q);

    case (state_q)
      STATE_IDLE: begin
        if (accept) begin
          valid_d        = 1'b1;
          res_d.status   = ST_OK;
          res_d.found    = 1'b0;
          res_d.position = '0;
          case (cmd_i.mode)
            MODE_PUSH_FRONT: begin
              if (cnt_q >= CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                front_d   = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
                ram_we    = 1'b1;
                ram_waddr = front_d;
                cnt_d     = cnt_q + 1'b1;
              end
            end
            MODE_PUSH_BACK: begin
              if (cnt_q >= CNT_W'(CAPACITY)) begin
                res_d.status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(front_q, cnt_q);
                cnt_d     = cnt_q + 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                front_d = slot_of(front_q, CNT_W'(1));
                cnt_d   = cnt_q - 1'b1;
              end
            end
            MODE_POP_BACK: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            MODE_SEARCH: begin
              if (cnt_q == '0) begin
                res_d.status = ST_EMPTY;
              end else begin
                // Result follows from the walk instead.
                valid_d = 1'b0;
                key_d   = word_in;
                iss_d   = '0;
                state_d = STATE_SEARCH;
              end
            end
            default: begin
              res_d.status = ST_OK;
            end
          endcase
          res_d.occupancy = OCC_W'(cnt_d);
        end
      end
      STATE_SEARCH: begin
        // Issue one read per cycle until every stored entry is requested or a match ends the walk.
        if (iss_q < cnt_q) begin
          ram_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_off_d = iss_q;
          iss_d     = iss_q + 1'b1;
        end
        // Compare the entry returned by the store.
        if (cmp_vld_q) begin
          if (ram_rdata == key_q) begin
            valid_d         = 1'b1;
            res_d.status    = ST_OK;
            res_d.found     = 1'b1;
            res_d.position  = POS_W'(cmp_off_q);
            res_d.occupancy = OCC_W'(cnt_q);
            cmp_vld_d       = 1'b0;
            state_d         = STATE_IDLE;
          end else if (cmp_off_q == cnt_q - 1'b1) begin
            valid_d         = 1'b1;
            res_d.status    = ST_MISSING;
            res_d.found     = 1'b0;
            res_d.position  = '0;
            res_d.occupancy = OCC_W'(cnt_q);
            cmp_vld_d       = 1'b0;
            state_d         = STATE_IDLE;
          end
        end
      end
      default: begin
        state_d = STATE_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= STATE_IDLE;
      front_q   <= '0;
      cnt_q     <= '0;
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      cnt_q     <= cnt_d;
      iss_q     <= iss_d;
      cmp_vld_q <= cmp_vld_d;
      valid_q   <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_off_q <= cmp_off_d;
    key_q     <= key_d;
    res_q     <= res_d;
  end

  assign busy_o  = (state_q != STATE_IDLE);
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  // A command other than search gives its result in the next cycle.
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i.mode != MODE_SEARCH) |=> valid_o)
    else $error("missing single-cycle result");

  // A search leaves the count and front untouched while it walks.
  a_search_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == STATE_SEARCH) |=> ($stable(cnt_q) && $stable(front_q)))
    else $error("deque state changed during a search");

  // A match is always reported with status ok.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.found) |-> (res_o.status == ST_OK))
    else $error("found flag with non-ok status");

endmodule
